[hw/rtl/ssac_pkg.sv]
package ssac_pkg;

  // Default sizes of the arc store and the arc fields.
  localparam int MAX_ARCS_DEF  = 64;
  localparam int NODE_BITS_DEF = 8;
  localparam int COST_BITS_DEF = 32;

  // Width of the rank field of a result item.
  localparam int RANK_BITS = 6;

  // Commands that the top level broadcasts to every cell of the chain.
  typedef struct packed {
    logic load;   // insert the new arc at its sorted place
    logic shift;  // move every arc one cell toward the head
  } cell_ctl_t;

endpackage

[hw/rtl/ssac_cell.sv]
module ssac_cell #(
  parameter int NODE_BITS = ssac_pkg::NODE_BITS_DEF,
  parameter int COST_BITS = ssac_pkg::COST_BITS_DEF,
  localparam int ARC_W = 2 * NODE_BITS + COST_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssac_pkg::cell_ctl_t ctl,
  // Arc to insert, fields {cost, end, start} from the top bit down.
  input  logic [ARC_W-1:0]   new_arc,
  // Neighbor toward the head of the chain.
  input  logic [ARC_W-1:0]   lft_arc,
  input  logic               lft_valid,
  input  logic               lft_ins,
  // Neighbor toward the tail of the chain.
  input  logic [ARC_W-1:0]   rgt_arc,
  input  logic               rgt_valid,
  output logic [ARC_W-1:0]   arc,
  output logic               valid,
  output logic               ins
);

  logic [ARC_W-1:0] arc_r;
  logic [ARC_W-1:0] arc_nxt;
  logic             valid_r;
  logic             valid_nxt;
  logic             gt;

  // The cell lies at or beyond the insertion point when it is empty or holds
  // a strictly greater cost; equal costs stay ahead of the new arc.
  assign gt  = valid_r && (arc_r[2*NODE_BITS +: COST_BITS] >
                           new_arc[2*NODE_BITS +: COST_BITS]);
  assign ins = gt || !valid_r;

  // Next contents: take the left neighbor's arc when it moves up too,
  // take the new arc at the insertion point, or shift toward the head.
  always_comb begin
    arc_nxt   = arc_r;
    valid_nxt = valid_r;
    if (ctl.shift) begin
      arc_nxt   = rgt_arc;
      valid_nxt = rgt_valid;
    end else if (ctl.load && ins) begin
      if (lft_ins) begin
        arc_nxt   = lft_arc;
        valid_nxt = lft_valid;
      end else begin
        arc_nxt   = new_arc;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arc_r <= arc_nxt;
  end

  assign arc   = arc_r;
  assign valid = valid_r;

endmodule

[hw/rtl/stable_sort_arcs_by_cost.sv]
// Loading: one arc item per cycle; each arc taken while not full lands in its
// sorted cell at the edge that accepts it, as every cell compares against it
// in parallel. Output: after the item marked last, the arcs leave one per cycle
// from the head cell while out_tready is high, N result items for N stored
// arcs; no input is taken then. Results start in the cycle after the last
// arc is accepted. Reset clears cell valid bits, arc count and overflow flag.
module stable_sort_arcs_by_cost #(
  parameter int MAX_ARCS  = ssac_pkg::MAX_ARCS_DEF,
  parameter int NODE_BITS = ssac_pkg::NODE_BITS_DEF,
  parameter int COST_BITS = ssac_pkg::COST_BITS_DEF,
  localparam int ARC_W = 2 * NODE_BITS + COST_BITS,
  localparam int IN_W  = ((ARC_W + 7) / 8) * 8,
  localparam int OUT_W = ((ARC_W + ssac_pkg::RANK_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // start_node, end_node, arc_cost
  input  logic             in_tlast,   // last_arc
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // out_start, out_end, out_cost, arc_rank
  output logic             out_tlast,  // last_out
  output logic             out_tuser   // overflow
);

  localparam int CNT_W = $clog2(MAX_ARCS + 1);

  logic [ARC_W-1:0]    cell_arc [MAX_ARCS];
  logic [MAX_ARCS-1:0] cell_valid;
  logic [MAX_ARCS-1:0] cell_ins;
  ssac_pkg::cell_ctl_t ctl;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rank_r, rank_nxt;
  logic             emit_r, emit_nxt;
  logic             ovf_r, ovf_nxt;
  logic             full;
  logic             in_fire;
  logic             out_fire;
  logic             out_done;

  // Handshake and chain commands.
  assign full     = (count_r == CNT_W'(MAX_ARCS));
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign out_done = out_fire && out_tlast;
  assign ctl.load  = in_fire && !full;
  assign ctl.shift = out_fire;

  // Chain of cells, head at index 0.
  for (genvar i = 0; i < MAX_ARCS; i++) begin : g_cell
    logic [ARC_W-1:0] lft_arc;
    logic             lft_valid;
    logic             lft_ins;
    logic [ARC_W-1:0] rgt_arc;
    logic             rgt_valid;

    if (i == 0) begin : g_head
      assign lft_arc   = '0;
      assign lft_valid = 1'b0;
      assign lft_ins   = 1'b0;
    end else begin : g_body
      assign lft_arc   = cell_arc[i-1];
      assign lft_valid = cell_valid[i-1];
      assign lft_ins   = cell_ins[i-1];
    end

    if (i == MAX_ARCS - 1) begin : g_tail
      assign rgt_arc   = '0;
      assign rgt_valid = 1'b0;
    end else begin : g_inner
      assign rgt_arc   = cell_arc[i+1];
      assign rgt_valid = cell_valid[i+1];
    end

    ssac_cell #(
      .NODE_BITS(NODE_BITS),
      .COST_BITS(COST_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .new_arc  (in_tdata[ARC_W-1:0]),
      .lft_arc  (lft_arc),
      .lft_valid(lft_valid),
      .lft_ins  (lft_ins),
      .rgt_arc  (rgt_arc),
      .rgt_valid(rgt_valid),
      .arc      (cell_arc[i]),
      .valid    (cell_valid[i]),
      .ins      (cell_ins[i])
    );
  end

  // Load and output phase control.
  always_comb begin
    count_nxt = count_r;
    rank_nxt  = rank_r;
    emit_nxt  = emit_r;
    ovf_nxt   = ovf_r;
    if (in_fire) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (in_tlast) begin
        emit_nxt = 1'b1;
      end
    end
    if (out_fire) begin
      rank_nxt = rank_r + CNT_W'(1);
    end
    if (out_done) begin
      count_nxt = '0;
      rank_nxt  = '0;
      emit_nxt  = 1'b0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rank_r  <= '0;
      emit_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rank_r  <= rank_nxt;
      emit_r  <= emit_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Result item comes straight from the head cell.
  assign in_tready  = !emit_r;
  assign out_tvalid = emit_r;
  assign out_tdata  = OUT_W'({ssac_pkg::RANK_BITS'(rank_r), cell_arc[0]});
  assign out_tlast  = (rank_r == count_r - CNT_W'(1));
  assign out_tuser  = ovf_r;

  // The two phases never overlap.
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output phase overlap");

  // While results go out, the head cell holds a stored arc.
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cell_valid[0])
    else $error("result item from an empty head cell");

  // While loading, the valid cells match the arc count.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    !emit_r |-> ($countones(cell_valid) == int'(count_r)))
    else $error("valid cells disagree with arc count");

  // The final result leaves the chain empty and ready for a new set.
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_done |=> (cell_valid == '0) && (count_r == '0) && !ovf_r)
    else $error("chain not empty after final result");

  // The count never passes capacity.
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ARCS))
    else $error("arc count above capacity");

endmodule
